// ===== hw/rtl/nearest_neighbor_scale_address_defines.svh =====
// assertion macros shared by the address generator
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_DEFINES_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_DEFINES_SVH

// same-cycle implication, quiet during reset
`define NNSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define NNSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nnsa_pkg.sv =====
`default_nettype none

package nnsa_pkg;

    // fixed field widths
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int IDX_W       = 24;
    localparam int RC_W        = 12;
    localparam int MAX_DIM_DEF = 4096;

    // register reset values
    localparam logic [CFG_W-1:0] SRC_W_RST = 13'd640;
    localparam logic [CFG_W-1:0] SRC_H_RST = 13'd480;
    localparam logic [CFG_W-1:0] TGT_W_RST = 13'd0;
    localparam logic [CFG_W-1:0] TGT_H_RST = 13'd0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_W = 4'd0,
        REG_SRC_H = 4'd1,
        REG_TGT_W = 4'd2,
        REG_TGT_H = 4'd3
    } cfg_reg_t;

    // flags that ride along the pipeline
    typedef struct packed {
        logic oor;
        logic last;
    } flag_t;

    // one result item
    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic [RC_W-1:0]  source_col;
        logic [RC_W-1:0]  source_row;
        logic             out_of_range;
        logic             last_pixel;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nnsa_div_cell.sv =====
`default_nettype none

// one restoring division step for quotient bit K, registered
module nnsa_div_cell #(
    parameter int RW  = 25,
    parameter int DVW = 13,
    parameter int QW  = 12,
    parameter int K   = 0
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [RW-1:0]  rem_in,
    input  wire logic [QW-1:0]  q_in,
    input  wire logic [DVW-1:0] div,
    output logic      [RW-1:0]  rem_reg,
    output logic      [QW-1:0]  q_reg
);

    logic [RW-1:0] shifted;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] q_next;

    // compare against the divisor shifted to this bit, subtract if it fits
    always_comb
    begin
        shifted  = RW'(div) << K;
        ge       = (rem_in >= shifted);
        rem_next = ge ? (rem_in - shifted) : rem_in;
        q_next   = q_in;
        q_next[K] = ge;
    end

    // cell registers, held while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_neighbor_scale_address.sv =====
`default_nettype none

`include "nearest_neighbor_scale_address_defines.svh"

// Nearest-neighbor scaling address generator. Each request carries the row-major
// index of a pixel of the resized image; the block returns the source pixel's
// column, row and row-major index, plus out_of_range (other fields zero) and
// last_pixel flags. It accepts one request per clock while in_stall is low and
// returns one result per clock while out_stall is low. Two chains of division
// cells do the work, one quotient bit per cell: the first splits the
// index into row and column, the second scales them to the source grid. A
// target size of 0 follows the source size, sizes above MAX_DIM are clipped,
// a source size of 0 counts as 1. Write the registers only while idle.
module nearest_neighbor_scale_address import nnsa_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [IDX_W-1:0]     target_index,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [IDX_W-1:0]     source_index,
    output logic      [RC_W-1:0]      source_col,
    output logic      [RC_W-1:0]      source_row,
    output logic                      out_of_range,
    output logic                      last_pixel,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int DW    = $clog2(MAX_DIM);
    localparam int DIM_W = DW + 1;
    localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam int RW1   = (IDX_W > DIM_W + DW) ? IDX_W : DIM_W + DW;
    localparam int RW2   = 2 * DIM_W;
    localparam int AW    = (IDX_W > RW2) ? IDX_W : RW2;
    localparam int PW    = DW + DIM_W + 1;

    // configuration registers
    logic [CFG_W-1:0] src_w_reg;
    logic [CFG_W-1:0] src_h_reg;
    logic [CFG_W-1:0] tgt_w_reg;
    logic [CFG_W-1:0] tgt_h_reg;

    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic [AW-1:0]    area_next;
    logic [AW-1:0]    area_reg;

    logic en;

    // front stages
    logic             s0_v_reg;
    logic [IDX_W-1:0] s0_idx_reg;
    logic             s1_v_reg;
    flag_t            s1_flag_reg;
    logic [RW1-1:0]   s1_rem_reg;
    flag_t            s1_flag_next;

    // first division chain
    logic [RW1-1:0] c1_rem [DW+1];
    logic [DW-1:0]  c1_q   [DW+1];
    logic           c1_v_reg    [DW];
    flag_t          c1_flag_reg [DW];

    // multiply stage
    logic            m_v_reg;
    flag_t           m_flag_reg;
    logic [RW2-1:0]  pc_reg;
    logic [RW2-1:0]  pr_reg;
    logic [DIM_W-1:0] col;

    // second division chain, column and row side by side
    logic [RW2-1:0] c2c_rem [DW+1];
    logic [DW-1:0]  c2c_q   [DW+1];
    logic [RW2-1:0] c2r_rem [DW+1];
    logic [DW-1:0]  c2r_q   [DW+1];
    logic           c2_v_reg    [DW];
    flag_t          c2_flag_reg [DW];

    // tail and output buffer
    logic [PW-1:0] sidx_full;
    res_t          tail;
    logic          tail_v;
    res_t          out_reg;
    res_t          out_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    res_t          skid_reg;
    res_t          skid_next;
    logic          skid_full_reg;
    logic          skid_full_next;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] if_zero);
        logic [CMP_W-1:0] ext;
        logic [DIM_W-1:0] d;
        ext = CMP_W'(v);
        if (ext == '0)
            d = if_zero;
        else if (ext > CMP_W'(MAX_DIM))
            d = DIM_W'(MAX_DIM);
        else
            d = DIM_W'(ext);
        return d;
    endfunction

    // register writes, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SRC_W_RST;
            src_h_reg <= SRC_H_RST;
            tgt_w_reg <= TGT_W_RST;
            tgt_h_reg <= TGT_H_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_W: src_w_reg <= cfg_data;
                REG_SRC_H: src_h_reg <= cfg_data;
                REG_TGT_W: tgt_w_reg <= cfg_data;
                REG_TGT_H: tgt_h_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // effective sizes and target area
    always_comb
    begin
        sw        = clamp_dim(src_w_reg, DIM_W'(1));
        sh        = clamp_dim(src_h_reg, DIM_W'(1));
        tw        = clamp_dim(tgt_w_reg, sw);
        th        = clamp_dim(tgt_h_reg, sh);
        area_next = AW'(RW2'(tw) * RW2'(th));
    end

    always_ff @(posedge clk)
    begin
        area_reg <= area_next;
    end

    // whole pipeline moves unless the skid entry is occupied
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // input register and range check stage
    always_comb
    begin
        s1_flag_next.oor  = (AW'(s0_idx_reg) >= area_reg);
        s1_flag_next.last = (AW'(s0_idx_reg) == area_reg - AW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            m_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            s0_v_reg <= in_valid;
            s1_v_reg <= s0_v_reg;
            m_v_reg  <= c1_v_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_idx_reg  <= target_index;
            s1_flag_reg <= s1_flag_next;
            s1_rem_reg  <= RW1'(s0_idx_reg);
        end
    end

    assign c1_rem[0] = s1_rem_reg;
    assign c1_q[0]   = '0;

    // row and column of the target pixel, one quotient bit per cell
    for (genvar i = 0; i < DW; i++)
    begin : g_c1
        nnsa_div_cell #(
            .RW  (RW1),
            .DVW (DIM_W),
            .QW  (DW),
            .K   (DW - 1 - i)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (c1_rem[i]),
            .q_in    (c1_q[i]),
            .div     (tw),
            .rem_reg (c1_rem[i+1]),
            .q_reg   (c1_q[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c1_v_reg[i] <= 1'b0;
            else if (en)
                c1_v_reg[i] <= (i == 0) ? s1_v_reg : c1_v_reg[(i == 0) ? 0 : i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                c1_flag_reg[i] <= (i == 0) ? s1_flag_reg : c1_flag_reg[(i == 0) ? 0 : i-1];
        end
    end

    // scale column and row by the source size
    assign col = DIM_W'(c1_rem[DW]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_flag_reg <= c1_flag_reg[DW-1];
            pc_reg     <= RW2'(col) * RW2'(sw);
            pr_reg     <= RW2'(c1_q[DW]) * RW2'(sh);
        end
    end

    assign c2c_rem[0] = pc_reg;
    assign c2c_q[0]   = '0;
    assign c2r_rem[0] = pr_reg;
    assign c2r_q[0]   = '0;

    // source column and row, one quotient bit per cell
    for (genvar i = 0; i < DW; i++)
    begin : g_c2
        nnsa_div_cell #(
            .RW  (RW2),
            .DVW (DIM_W),
            .QW  (DW),
            .K   (DW - 1 - i)
        ) u_col (
            .clk     (clk),
            .en      (en),
            .rem_in  (c2c_rem[i]),
            .q_in    (c2c_q[i]),
            .div     (tw),
            .rem_reg (c2c_rem[i+1]),
            .q_reg   (c2c_q[i+1])
        );

        nnsa_div_cell #(
            .RW  (RW2),
            .DVW (DIM_W),
            .QW  (DW),
            .K   (DW - 1 - i)
        ) u_row (
            .clk     (clk),
            .en      (en),
            .rem_in  (c2r_rem[i]),
            .q_in    (c2r_q[i]),
            .div     (th),
            .rem_reg (c2r_rem[i+1]),
            .q_reg   (c2r_q[i+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c2_v_reg[i] <= 1'b0;
            else if (en)
                c2_v_reg[i] <= (i == 0) ? m_v_reg : c2_v_reg[(i == 0) ? 0 : i-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                c2_flag_reg[i] <= (i == 0) ? m_flag_reg : c2_flag_reg[(i == 0) ? 0 : i-1];
        end
    end

    // source index and result assembly, fields cleared past the area
    always_comb
    begin
        sidx_full = PW'(c2r_q[DW]) * PW'(sw) + PW'(c2c_q[DW]);
        tail_v    = c2_v_reg[DW-1];
        tail      = '0;
        tail.out_of_range = c2_flag_reg[DW-1].oor;
        if (!c2_flag_reg[DW-1].oor)
        begin
            tail.source_index = IDX_W'(sidx_full);
            tail.source_col   = RC_W'(c2c_q[DW]);
            tail.source_row   = RC_W'(c2r_q[DW]);
            tail.last_pixel   = c2_flag_reg[DW-1].last;
        end
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (en)
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_next = tail_v;
                out_next       = tail;
            end
            else if (tail_v)
            begin
                skid_full_next = 1'b1;
                skid_next      = tail;
            end
        end
        else if (!out_stall)
        begin
            out_next       = skid_reg;
            skid_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign source_index = out_reg.source_index;
    assign source_col   = out_reg.source_col;
    assign source_row   = out_reg.source_row;
    assign out_of_range = out_reg.out_of_range;
    assign last_pixel   = out_reg.last_pixel;

    // checks
    `NNSA_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_full_reg, out_valid_reg,
        "skid entry held without a result in the output register")
    `NNSA_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_full_reg && out_stall,
        skid_full_reg && $stable(skid_reg), "skid entry lost while output stalled")
    `NNSA_ASSERT_NOW(a_oor_clear, clk, rst_n, out_valid_reg && out_reg.out_of_range,
        out_reg.source_index == '0 && !out_reg.last_pixel,
        "out of range result carries nonzero fields")
    `NNSA_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_full_reg && !out_stall,
        !skid_full_reg && out_valid_reg, "skid entry not moved on output accept")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none

module tb_top;
    import nnsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_PHASES     = 8;
    localparam int RANDOM_PER_PHASE = 140;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [IDX_W-1:0]     target_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     source_index;
    logic [RC_W-1:0]      source_col;
    logic [RC_W-1:0]      source_row;
    logic                 out_of_range;
    logic                 last_pixel;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // register copies for the address predictor
    logic [CFG_W-1:0] src_w_reg = SRC_W_RST;
    logic [CFG_W-1:0] src_h_reg = SRC_H_RST;
    logic [CFG_W-1:0] tgt_w_reg = TGT_W_RST;
    logic [CFG_W-1:0] tgt_h_reg = TGT_H_RST;

    logic [IDX_W-1:0] pixel_q[$];
    res_t             src_addr_q[$];

    bit hold_input;
    bit in_taken;
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_timer;
    int mismatches;
    int results_seen;
    int oor_seen;
    int last_seen;
    int idle_cycles;

    nearest_neighbor_scale_address dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target_index (target_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .source_index (source_index),
        .source_col   (source_col),
        .source_row   (source_row),
        .out_of_range (out_of_range),
        .last_pixel   (last_pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // effective dimension: zero takes the fallback, big values clip to the max
    function automatic longint unsigned eff_dim(logic [CFG_W-1:0] v,
                                                longint unsigned if_zero);
        longint unsigned d;
        d = v;
        if (d == 0)
            d = if_zero;
        if (d > MAX_DIM_DEF)
            d = MAX_DIM_DEF;
        return d;
    endfunction

    function automatic longint unsigned target_area();
        longint unsigned sw;
        longint unsigned sh;
        sw = eff_dim(src_w_reg, 1);
        sh = eff_dim(src_h_reg, 1);
        return eff_dim(tgt_w_reg, sw) * eff_dim(tgt_h_reg, sh);
    endfunction

    function automatic res_t map_to_source(logic [IDX_W-1:0] idx);
        res_t r;
        longint unsigned sw;
        longint unsigned sh;
        longint unsigned tw;
        longint unsigned th;
        longint unsigned col;
        longint unsigned row;
        longint unsigned scol;
        longint unsigned srow;
        longint unsigned sidx;
        r = '0;
        sw = eff_dim(src_w_reg, 1);
        sh = eff_dim(src_h_reg, 1);
        tw = eff_dim(tgt_w_reg, sw);
        th = eff_dim(tgt_h_reg, sh);
        if (idx >= tw * th)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        col = idx % tw;
        row = idx / tw;
        scol = (col * sw) / tw;
        srow = (row * sh) / th;
        sidx = srow * sw + scol;
        r.source_index = sidx[IDX_W-1:0];
        r.source_col   = scol[RC_W-1:0];
        r.source_row   = srow[RC_W-1:0];
        r.last_pixel   = (idx == tw * th - 1);
        return r;
    endfunction

    // input driver: bursts and gaps, payload held while stalled
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_taken))
        begin
        end
        else if (!hold_input && pixel_q.size() > 0 && gap_left == 0)
        begin
            in_valid <= 1'b1;
            target_index <= pixel_q[0];
            burst_left = burst_left - 1;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
        begin
            in_valid <= 1'b0;
            if (gap_left > 0)
                gap_left = gap_left - 1;
        end
    end

    // output stall pattern: free, light or heavy stretches
    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_timer = $urandom_range(10, 80);
        end
        stall_timer = stall_timer - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // request capture and prediction
    always @(posedge clk)
    begin
        in_taken = in_valid && !in_stall && rst_n;
        if (in_taken)
        begin
            src_addr_q.push_back(map_to_source(target_index));
            void'(pixel_q.pop_front());
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (src_addr_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected, index %0d", source_index);
            end
            else
            begin
                want = src_addr_q.pop_front();
                if (want.out_of_range) oor_seen++;
                if (want.last_pixel) last_seen++;
                if (source_index !== want.source_index || source_col !== want.source_col ||
                    source_row !== want.source_row || out_of_range !== want.out_of_range ||
                    last_pixel !== want.last_pixel)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: exp idx %0d col %0d row %0d oor %0b last %0b, ",
                                  "got %0d %0d %0d %0b %0b"},
                                 want.source_index, want.source_col, want.source_row,
                                 want.out_of_range, want.last_pixel, source_index,
                                 source_col, source_row, out_of_range, last_pixel);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_SRC_W: src_w_reg = val;
            REG_SRC_H: src_h_reg = val;
            REG_TGT_W: tgt_w_reg = val;
            REG_TGT_H: tgt_h_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // every request sent so far has come back, queue may still hold more
    task automatic wait_results();
        do @(posedge clk);
        while (in_valid || src_addr_q.size() > 0);
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pixel_q.size() > 0 || in_valid || src_addr_q.size() > 0);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim(bit allow_zero);
        if ($urandom_range(0, 9) == 0)
            return CFG_W'($urandom_range(0, 8191));
        return CFG_W'($urandom_range(allow_zero ? 0 : 1, 48));
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(longint unsigned area);
        if ($urandom_range(0, 4) == 0)
            return IDX_W'($urandom_range(0, 24'hFFFFFF));
        return IDX_W'($urandom_range(0, int'(area - 1)));
    endfunction

    // stimulus: one register setting per phase, directed then random requests
    initial
    begin
        longint unsigned area;
        longint unsigned tw;
        rst_n = 1'b0;
        in_valid = 1'b0;
        target_index = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SRC_W;
        cfg_data = '0;
        burst_left = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: ;
                1:
                begin
                    write_reg(REG_SRC_W, 13'd1);
                    write_reg(REG_SRC_H, 13'd1);
                    write_reg(REG_TGT_W, 13'd0);
                    write_reg(REG_TGT_H, 13'd0);
                    write_reg(REG_UNUSED, 13'h1FFF);
                end
                2:
                begin
                    write_reg(REG_SRC_W, 13'd4096);
                    write_reg(REG_SRC_H, 13'd4096);
                    write_reg(REG_TGT_W, 13'd4096);
                    write_reg(REG_TGT_H, 13'd4096);
                end
                3:
                begin
                    write_reg(REG_SRC_W, 13'h1FFF);
                    write_reg(REG_SRC_H, 13'h1FFF);
                    write_reg(REG_TGT_W, 13'h1FFF);
                    write_reg(REG_TGT_H, 13'd5);
                end
                4:
                begin
                    write_reg(REG_SRC_W, 13'd0);
                    write_reg(REG_SRC_H, 13'd0);
                    write_reg(REG_TGT_W, 13'd7);
                    write_reg(REG_TGT_H, 13'd3);
                end
                5:
                begin
                    write_reg(REG_SRC_W, 13'd37);
                    write_reg(REG_SRC_H, 13'd23);
                    write_reg(REG_TGT_W, 13'd37);
                    write_reg(REG_TGT_H, 13'd23);
                end
                default:
                begin
                    write_reg(REG_SRC_W, pick_dim(1'b1));
                    write_reg(REG_SRC_H, pick_dim(1'b1));
                    write_reg(REG_TGT_W, pick_dim(1'b1));
                    write_reg(REG_TGT_H, pick_dim(1'b1));
                end
            endcase
            @(posedge clk);
            area = target_area();
            tw = eff_dim(tgt_w_reg, eff_dim(src_w_reg, 1));

            // corners of the target image and of the index field
            pixel_q.push_back('0);
            pixel_q.push_back(IDX_W'(area - 1));
            if (area <= 24'hFFFFFF)
                pixel_q.push_back(IDX_W'(area));
            pixel_q.push_back(24'hFFFFFF);
            pixel_q.push_back(24'h555555);
            pixel_q.push_back(24'hAAAAAA);
            pixel_q.push_back(IDX_W'(tw - 1));
            if (tw < area)
                pixel_q.push_back(IDX_W'(tw));

            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                pixel_q.push_back(pick_index(area));

            // pause the sender mid-phase until the pipe is empty
            do @(posedge clk);
            while (pixel_q.size() > RANDOM_PER_PHASE / 2);
            hold_input = 1'b1;
            wait_results();
            hold_input = 1'b0;

            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        $display("covered %0d register settings, %0d results checked", NUM_PHASES, results_seen);
        $display("out-of-range results %0d, last-pixel results %0d", oor_seen, last_seen);
        if (mismatches == 0 && src_addr_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("mismatches %0d, left over %0d", mismatches, src_addr_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/nnsa_pkg.sv
hw/rtl/nnsa_div_cell.sv
hw/rtl/nearest_neighbor_scale_address.sv
dv/tb_top.sv
